FILE: rtl/core/cer_pkg.sv
// ----------------------------------------------------------------------------
// Calculator expression reader package
// Phase type, result status codes, character codes and register map.
// ----------------------------------------------------------------------------
package cer_pkg;

   typedef enum logic [1:0] {
      PH_FIRST   = 2'd0,
      PH_OPER    = 2'd1,
      PH_SECOND  = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_COMPLETE    = 2'd0,
      ST_SECOND_POINT = 2'd1,
      ST_BAD_CHAR    = 2'd2,
      ST_BAD_OPERATOR = 2'd3
   } status_type;

   localparam logic [7:0] CH_DIGIT_0 = 8'd48;
   localparam logic [7:0] CH_DIGIT_9 = 8'd57;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_POINT   = 8'd46;
   localparam logic [7:0] CH_COMMA   = 8'd44;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   localparam logic [3:0] MAX_FRAC = 4'd15;

   localparam int REG_COUNT      = 4;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam int REG_OPERATOR_A = 0;
   localparam int REG_OPERATOR_B = 1;
   localparam int REG_OPERATOR_C = 2;
   localparam int REG_OPERATOR_D = 3;

   localparam logic [7:0] RESET_OPERATOR_A = 8'd43;
   localparam logic [7:0] RESET_OPERATOR_B = 8'd45;
   localparam logic [7:0] RESET_OPERATOR_C = 8'd42;
   localparam logic [7:0] RESET_OPERATOR_D = 8'd47;

endpackage

FILE: rtl/core/cer_chan_if.sv
// ----------------------------------------------------------------------------
// Calculator expression reader channels
// Valid/ready channels for character items and result items.
// ----------------------------------------------------------------------------
interface cer_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface cer_rsp_if #(
   parameter int MANTISSA_BITS = 48
);
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic signed [MANTISSA_BITS-1:0] first_mantissa;
   logic [3:0]                      first_frac_digits;
   logic [7:0]                      operator_char;
   logic signed [MANTISSA_BITS-1:0] second_mantissa;
   logic [3:0]                      second_frac_digits;

   modport source (
      output valid, output status, output first_mantissa, output first_frac_digits,
      output operator_char, output second_mantissa, output second_frac_digits,
      input ready
   );
   modport sink (
      input valid, input status, input first_mantissa, input first_frac_digits,
      input operator_char, input second_mantissa, input second_frac_digits,
      output ready
   );
endinterface

FILE: rtl/core/calculator_expression_reader.sv
// ----------------------------------------------------------------------------
// Calculator expression reader
// Parses number, operator, number from a character stream into results.
// ----------------------------------------------------------------------------
// One character item is taken per cycle and updates the parser state in the
// same cycle: the mantissa step is a multiply by ten (two shifts and an add)
// and one compare for saturation. A result item leaves through an output
// register backed by one skid entry, so input stalls only while both hold
// results that the sink has not taken. Operator codes are written over the
// APB port; only the first OPERATOR_COUNT registers (at most four) match.
// ----------------------------------------------------------------------------
module calculator_expression_reader
   import cer_pkg::*;
#(
   parameter int OPERATOR_COUNT = 4,
   parameter int MANTISSA_BITS  = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   cer_req_if.sink                  req_chan,
   cer_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int MB = MANTISSA_BITS;
   localparam logic [MB-1:0] MANT_MAX = {1'b0, {(MB-1){1'b1}}};

   typedef struct packed {
      status_type     status;
      logic [MB-1:0]  first_mantissa;
      logic [3:0]     first_frac;
      logic [7:0]     operator_char;
      logic [MB-1:0]  second_mantissa;
      logic [3:0]     second_frac;
   } result_type;

   logic [7:0]    op_ff [REG_COUNT];

   phase_type     phase_ff, phase_in;
   logic          at_first_ff, at_first_in;
   logic          negative_ff, negative_in;
   logic          in_fraction_ff, in_fraction_in;
   logic [MB-1:0] work_ff, work_in;
   logic [3:0]    work_frac_ff, work_frac_in;
   logic [MB-1:0] held_mant_ff, held_mant_in;
   logic [3:0]    held_frac_ff, held_frac_in;
   logic [7:0]    held_op_ff, held_op_in;

   logic          out_valid_ff, skid_valid_ff;
   result_type    out_ff, skid_ff;

   logic          accept, take, emit;
   result_type    result;
   logic [7:0]    c;
   logic          is_op, is_digit, is_point, sign_char, op_hit;
   logic [3:0]    digit;
   logic [MB+3:0] scaled;
   logic [MB-1:0] new_work;
   logic [3:0]    new_frac;

   // ---------------------------------------------------------------- csr
   assign pready = 1'b1;
   assign prdata = {{(CSR_DATA_BITS-8){1'b0}}, op_ff[paddr[3:2]]};

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff[REG_OPERATOR_A] <= RESET_OPERATOR_A;
         op_ff[REG_OPERATOR_B] <= RESET_OPERATOR_B;
         op_ff[REG_OPERATOR_C] <= RESET_OPERATOR_C;
         op_ff[REG_OPERATOR_D] <= RESET_OPERATOR_D;
      end else if (psel && penable && pwrite && pready) begin
         op_ff[paddr[3:2]] <= pwdata[7:0];
      end
   end

   // ---------------------------------------------------------------- parse
   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign c      = req_chan.char_code;

   always_comb begin
      is_op = 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
         if (i < OPERATOR_COUNT && op_ff[i] == c) begin
            is_op = 1'b1;
         end
      end
   end

   assign is_digit  = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   assign is_point  = (c == CH_POINT) || (c == CH_COMMA);
   assign digit     = 4'(c - CH_DIGIT_0);
   assign sign_char = (c == CH_MINUS) && !negative_ff && at_first_ff;
   assign op_hit    = (phase_ff == PH_FIRST) && !at_first_ff && is_op;
   assign scaled    = ({4'b0, work_ff} << 3) + ({4'b0, work_ff} << 1) + (MB+4)'(digit);

   always_comb begin
      new_work = work_ff;
      new_frac = work_frac_ff;
      if (is_digit && !(in_fraction_ff && work_frac_ff >= MAX_FRAC)) begin
         new_frac = work_frac_ff + 4'(in_fraction_ff);
         if (scaled > {4'b0, MANT_MAX}) begin
            new_work = MANT_MAX;
         end else begin
            new_work = scaled[MB-1:0];
         end
      end
   end

   always_comb begin
      emit   = 1'b0;
      result = '0;
      case (phase_ff)
         PH_OPER: begin
            if (!is_op) begin
               emit          = 1'b1;
               result.status = ST_BAD_OPERATOR;
            end
         end
         PH_FIRST, PH_SECOND: begin
            if (c == CH_NEWLINE) begin
               if (phase_ff == PH_SECOND) begin
                  emit                   = 1'b1;
                  result.status          = ST_COMPLETE;
                  result.first_mantissa  = held_mant_ff;
                  result.first_frac      = held_frac_ff;
                  result.operator_char   = held_op_ff;
                  result.second_mantissa = negative_ff ? -work_ff : work_ff;
                  result.second_frac     = work_frac_ff;
               end
            end else if (is_point && in_fraction_ff) begin
               emit          = 1'b1;
               result.status = ST_SECOND_POINT;
            end else if (!is_digit && !is_point && !op_hit && !sign_char) begin
               emit          = 1'b1;
               result.status = ST_BAD_CHAR;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      at_first_in    = at_first_ff;
      negative_in    = negative_ff;
      in_fraction_in = in_fraction_ff;
      work_in        = work_ff;
      work_frac_in   = work_frac_ff;
      held_mant_in   = held_mant_ff;
      held_frac_in   = held_frac_ff;
      held_op_in     = held_op_ff;
      case (phase_ff)
         PH_DISCARD: begin
            if (c == CH_NEWLINE) begin
               phase_in = PH_FIRST;
            end
         end
         PH_OPER: begin
            if (is_op) begin
               held_op_in = c;
               phase_in   = PH_SECOND;
            end else begin
               phase_in   = (c == CH_NEWLINE) ? PH_FIRST : PH_DISCARD;
            end
         end
         default: begin
            if (c == CH_NEWLINE) begin
               if (phase_ff == PH_FIRST) begin
                  held_mant_in = negative_ff ? -work_ff : work_ff;
                  held_frac_in = work_frac_ff;
                  phase_in     = PH_OPER;
               end else begin
                  phase_in     = PH_FIRST;
               end
            end else if (is_point && in_fraction_ff) begin
               phase_in      = PH_DISCARD;
            end else if (!is_digit && !is_point && !op_hit && !sign_char) begin
               phase_in      = PH_DISCARD;
            end else if (op_hit) begin
               held_op_in   = c;
               held_mant_in = (negative_ff || sign_char) ? -new_work : new_work;
               held_frac_in = new_frac;
               phase_in     = PH_SECOND;
            end else begin
               at_first_in    = 1'b0;
               negative_in    = negative_ff || sign_char;
               in_fraction_in = in_fraction_ff || is_point;
               work_in        = new_work;
               work_frac_in   = new_frac;
            end
         end
      endcase
      // restart the number on every phase change
      if (phase_in != phase_ff || emit) begin
         at_first_in    = 1'b1;
         negative_in    = 1'b0;
         in_fraction_in = 1'b0;
         work_in        = '0;
         work_frac_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FIRST;
         at_first_ff    <= 1'b1;
         negative_ff    <= 1'b0;
         in_fraction_ff <= 1'b0;
         work_ff        <= '0;
         work_frac_ff   <= '0;
         held_mant_ff   <= '0;
         held_frac_ff   <= '0;
         held_op_ff     <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         at_first_ff    <= at_first_in;
         negative_ff    <= negative_in;
         in_fraction_ff <= in_fraction_in;
         work_ff        <= work_in;
         work_frac_ff   <= work_frac_in;
         held_mant_ff   <= held_mant_in;
         held_frac_ff   <= held_frac_in;
         held_op_ff     <= held_op_in;
      end
   end

   // ---------------------------------------------------------------- output
   assign take = out_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept && emit;
         end
      end else if (accept && emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (!skid_valid_ff) begin
         skid_ff <= result;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.status             = out_ff.status;
   assign rsp_chan.first_mantissa     = out_ff.first_mantissa;
   assign rsp_chan.first_frac_digits  = out_ff.first_frac;
   assign rsp_chan.operator_char      = out_ff.operator_char;
   assign rsp_chan.second_mantissa    = out_ff.second_mantissa;
   assign rsp_chan.second_frac_digits = out_ff.second_frac;

   // ---------------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_chan.ready))
      else $error("skid filled without output stall");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != ST_COMPLETE |->
         out_ff.first_mantissa == '0 && out_ff.second_mantissa == '0 &&
         out_ff.operator_char == '0 && out_ff.first_frac == '0 &&
         out_ff.second_frac == '0)
      else $error("error result carries nonzero fields");

   a_oper_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_OPER |-> work_ff == '0 && !negative_ff && at_first_ff)
      else $error("number not restarted in operator phase");

   a_first_char_clean: assert property (@(posedge clock) disable iff (reset)
      at_first_ff |-> work_ff == '0 && !in_fraction_ff && work_frac_ff == '0)
      else $error("number content before first character");

endmodule
